// File: design/lesf_pkg.sv
// shared types and constants of the largest empty square finder
package lesf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;

    localparam int CHAR_W      = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = 10;
    localparam int HGT_W       = 11;
    localparam int SIZE_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CHAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_CHAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 2'd2;

    localparam logic [CHAR_W-1:0] RESET_EMPTY_CHAR    = 8'd46;
    localparam logic [CHAR_W-1:0] RESET_OBSTACLE_CHAR = 8'd111;
    localparam logic [HGT_W-1:0]  RESET_MAP_HEIGHT    = 11'd1;

    typedef struct packed {
        logic [CHAR_W-1:0] empty_char;
        logic [CHAR_W-1:0] obstacle_char;
        logic [HGT_W-1:0]  map_height;
    } t_cfg;

    // one classified beat
    typedef struct packed {
        logic eol;
        logic is_empty;
        logic bad_char;
    } t_item;

endpackage

// File: design/lesf_front.sv
// front end: classifies each incoming beat against the configured characters
module lesf_front (
    input  lesf_pkg::t_cfg              i_cfg,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tlast,
    input  logic [lesf_pkg::CHAR_W-1:0] i_s_char,
    input  logic                        i_q_ready,
    output logic                        o_s_tready,
    output logic                        o_q_push,
    output lesf_pkg::t_item             o_q_item
);

    logic w_is_empty;
    logic w_is_obst;

    assign w_is_empty = (i_s_char == i_cfg.empty_char);
    assign w_is_obst  = (i_s_char == i_cfg.obstacle_char);

    assign o_s_tready        = i_q_ready;
    assign o_q_push          = i_s_tvalid & i_q_ready;
    assign o_q_item.eol      = i_s_tlast;
    assign o_q_item.is_empty = ~i_s_tlast & w_is_empty;
    assign o_q_item.bad_char = ~i_s_tlast & ~w_is_empty & ~w_is_obst;

endmodule

// File: design/lesf_queue.sv
// short queue of classified beats between front and back end
module lesf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lesf_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_ready,
    output logic            o_valid,
    output lesf_pkg::t_item o_item
);

    lesf_pkg::t_item                 r_mem [lesf_pkg::QUEUE_DEPTH];
    logic [lesf_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [lesf_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [lesf_pkg::QCNT_W-1:0]     r_count;
    logic [lesf_pkg::QCNT_W-1:0]     n_count;

    assign o_ready = (r_count != lesf_pkg::QCNT_W'(lesf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/lesf_back.sv
// back end: row and column tracking, line buffer, square sizing and result register
module lesf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lesf_pkg::t_cfg               i_cfg,
    input  logic                         i_q_valid,
    input  lesf_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic                         o_map_ok,
    output logic [lesf_pkg::SIZE_W-1:0]  o_side_len,
    output logic [lesf_pkg::ROW_W-1:0]   o_top_row,
    output logic [lesf_pkg::COL_W-1:0]   o_left_col
);

    localparam int SIZE_W = lesf_pkg::SIZE_W;
    localparam int COL_W  = lesf_pkg::COL_W;
    localparam int ROW_W  = lesf_pkg::ROW_W;
    localparam int CNT_W  = lesf_pkg::CNT_W;
    localparam int HGT_W  = lesf_pkg::HGT_W;

    // line buffer
    logic [SIZE_W-1:0] r_line [lesf_pkg::MAX_WIDTH];

    // tracking stage
    logic [CNT_W-1:0]  r_col_cnt;
    logic [HGT_W-1:0]  r_row_cnt;
    logic [CNT_W-1:0]  r_learned_w;
    logic              r_width_known;
    logic              r_map_err;

    // sizing stage
    logic              r_b_valid;
    logic              r_b_eol;
    logic              r_b_final;
    logic              r_b_ok;
    logic              r_b_empty;
    logic              r_b_use_up;
    logic [COL_W-1:0]  r_b_col;
    logic [ROW_W-1:0]  r_b_row;
    logic [SIZE_W-1:0] r_up_raw;
    logic [SIZE_W-1:0] r_left;
    logic [SIZE_W-1:0] r_diag;
    logic [SIZE_W-1:0] r_best_size;
    logic [ROW_W-1:0]  r_best_row;
    logic [COL_W-1:0]  r_best_col;

    logic              w_adv;
    logic              w_pop;
    logic              w_fire;
    logic              w_cell_fits;
    logic              w_use_up;
    logic              w_mismatch;
    logic              w_err_eol;
    logic [HGT_W:0]    w_rows_done;
    logic [HGT_W-1:0]  w_height;
    logic              w_final;
    logic              w_ok;
    logic [SIZE_W-1:0] w_up;
    logic [SIZE_W-1:0] w_min_ul;
    logic [SIZE_W-1:0] w_min3;
    logic [SIZE_W-1:0] w_size;
    logic [SIZE_W-1:0] w_tr;
    logic [SIZE_W-1:0] w_tc;
    logic              w_better;

    // only a finished map waiting on a full result register holds things up
    assign w_adv  = !(r_b_valid && r_b_eol && r_b_final && o_m_tvalid && !i_m_tready);
    assign w_pop  = i_q_valid && w_adv;
    assign w_fire = r_b_valid && w_adv;
    assign o_q_pop = w_pop;

    // tracking stage decisions
    assign w_cell_fits = (r_col_cnt < CNT_W'(lesf_pkg::MAX_WIDTH));
    assign w_use_up    = (r_row_cnt != '0) && r_width_known && (r_col_cnt < r_learned_w);
    assign w_mismatch  = r_width_known && (r_col_cnt != r_learned_w);
    assign w_err_eol   = r_map_err || w_mismatch;
    assign w_height    = (i_cfg.map_height == '0) ? HGT_W'(1) : i_cfg.map_height;
    assign w_rows_done = {1'b0, r_row_cnt} + 1'b1;
    assign w_final     = (w_rows_done >= {1'b0, w_height});
    assign w_ok        = !w_err_eol && (i_cfg.empty_char != i_cfg.obstacle_char)
                         && (w_height <= HGT_W'(lesf_pkg::MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt     <= '0;
            r_row_cnt     <= '0;
            r_learned_w   <= '0;
            r_width_known <= 1'b0;
            r_map_err     <= 1'b0;
            r_b_valid     <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= w_pop && (i_q_item.eol || w_cell_fits);
            if (w_pop) begin
                if (!i_q_item.eol) begin
                    if (w_cell_fits) begin
                        r_col_cnt <= r_col_cnt + 1'b1;
                        if (i_q_item.bad_char) begin
                            r_map_err <= 1'b1;
                        end
                    end else begin
                        // overflowing cell is dropped
                        r_map_err <= 1'b1;
                    end
                end else begin
                    r_col_cnt <= '0;
                    if (w_final) begin
                        r_row_cnt     <= '0;
                        r_learned_w   <= '0;
                        r_width_known <= 1'b0;
                        r_map_err     <= 1'b0;
                    end else begin
                        r_row_cnt <= w_rows_done[HGT_W-1:0];
                        r_map_err <= w_err_eol;
                        if (!r_width_known) begin
                            r_learned_w   <= r_col_cnt;
                            r_width_known <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    // sizing stage payload and line buffer read
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_b_eol    <= i_q_item.eol;
            r_b_final  <= w_final;
            r_b_ok     <= w_ok;
            r_b_empty  <= i_q_item.is_empty;
            r_b_use_up <= w_use_up;
            r_b_col    <= r_col_cnt[COL_W-1:0];
            r_b_row    <= r_row_cnt[ROW_W-1:0];
            if (!i_q_item.eol && w_cell_fits) begin
                r_up_raw <= r_line[r_col_cnt[COL_W-1:0]];
            end
        end
        if (w_fire && !r_b_eol) begin
            r_line[r_b_col] <= w_size;
        end
    end

    assign w_up     = r_b_use_up ? r_up_raw : '0;
    assign w_min_ul = (w_up < r_left) ? w_up : r_left;
    assign w_min3   = (w_min_ul < r_diag) ? w_min_ul : r_diag;
    assign w_size   = r_b_empty ? (w_min3 + 1'b1) : '0;
    assign w_tr     = SIZE_W'(r_b_row) + SIZE_W'(1) - w_size;
    assign w_tc     = SIZE_W'(r_b_col) + SIZE_W'(1) - w_size;
    assign w_better = (w_size != '0) &&
                      ((w_size > r_best_size) ||
                       ((w_size == r_best_size) &&
                        ((w_tr < SIZE_W'(r_best_row)) ||
                         ((w_tr == SIZE_W'(r_best_row)) && (w_tc < SIZE_W'(r_best_col))))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            o_m_tvalid  <= 1'b0;
        end else begin
            if (w_fire && r_b_eol && r_b_final) begin
                o_m_tvalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
            if (w_fire) begin
                if (!r_b_eol) begin
                    r_left <= w_size;
                    r_diag <= w_up;
                    if (w_better) begin
                        r_best_size <= w_size;
                        r_best_row  <= w_tr[ROW_W-1:0];
                        r_best_col  <= w_tc[COL_W-1:0];
                    end
                end else begin
                    r_left <= '0;
                    r_diag <= '0;
                    if (r_b_final) begin
                        r_best_size <= '0;
                        r_best_row  <= '0;
                        r_best_col  <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_b_eol && r_b_final) begin
            o_map_ok   <= r_b_ok;
            o_side_len <= r_b_ok ? r_best_size : '0;
            o_top_row  <= (r_b_ok && r_best_size != '0) ? r_best_row : '0;
            o_left_col <= (r_b_ok && r_best_size != '0) ? r_best_col : '0;
        end
    end

endmodule

// File: design/largest_empty_square_finder_core.sv
// top level of the largest empty square finder
//
// usage
//   slave stream: one beat per map character in row-major order, tlast high
//   marks end of row (tdata then ignored); tdata[7:0] is the cell character
//   master stream: one beat per finished map, after the configured number of
//   rows; tuser is map_ok, tdata holds size, top row and left column
//   config channel: index 0 empty char, 1 obstacle char, 2 map height;
//   always ready, write only while the block is idle
// throughput
//   one beat per cycle when not stalled, set by the line buffer read in the
//   tracking stage and its later write in the sizing stage
// result
//   the final end-of-row beat passes queue, sizing stage and result register
// reset
//   clears counters, best square, queue and result valid; the line buffer is
//   not cleared, entries are only read after the row above wrote them
// stalls
//   a held result stops the back end only when the next map is also done;
//   the four-entry queue keeps the input going meanwhile
module largest_empty_square_finder_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] cell_char
    input  logic                             i_s_tlast,   // action: end of row
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [31:0]                      o_m_tdata,   // [10:0] side length,
                                                          // [20:11] top_row,
                                                          // [30:21] left_col
    output logic                             o_m_tuser,   // [0] map_ok
    // config channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lesf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lesf_pkg::t_cfg                   r_cfg;
    lesf_pkg::t_item                  w_push_item;
    lesf_pkg::t_item                  w_head_item;
    logic                             w_push;
    logic                             w_pop;
    logic                             w_q_ready;
    logic                             w_q_valid;
    logic [lesf_pkg::SIZE_W-1:0]      w_size;
    logic [lesf_pkg::ROW_W-1:0]       w_row;
    logic [lesf_pkg::COL_W-1:0]       w_col;

    assign o_cfg_ready = 1'b1;

    // config registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.empty_char    <= lesf_pkg::RESET_EMPTY_CHAR;
            r_cfg.obstacle_char <= lesf_pkg::RESET_OBSTACLE_CHAR;
            r_cfg.map_height    <= lesf_pkg::RESET_MAP_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lesf_pkg::CFG_EMPTY_CHAR: begin
                    r_cfg.empty_char <= i_cfg_data[lesf_pkg::CHAR_W-1:0];
                end
                lesf_pkg::CFG_OBSTACLE_CHAR: begin
                    r_cfg.obstacle_char <= i_cfg_data[lesf_pkg::CHAR_W-1:0];
                end
                lesf_pkg::CFG_MAP_HEIGHT: begin
                    r_cfg.map_height <= i_cfg_data[lesf_pkg::HGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // classification of each beat
    lesf_front u_front (
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_s_char   (i_s_tdata),
        .i_q_ready  (w_q_ready),
        .o_s_tready (o_s_tready),
        .o_q_push   (w_push),
        .o_q_item   (w_push_item)
    );

    // decouples input from line buffer work
    lesf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_head_item)
    );

    // tracking, sizing and result register
    lesf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_head_item),
        .o_q_pop    (w_pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_map_ok   (o_m_tuser),
        .o_side_len (w_size),
        .o_top_row  (w_row),
        .o_left_col (w_col)
    );

    assign o_m_tdata = {1'b0, w_col, w_row, w_size};

endmodule

// File: design/lesf_checker.sv
// port level checks of the largest empty square finder, bound to the top level
module lesf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    // no result straight after reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a failed map carries no square
    a_bad_map_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 32'd0))
        else $error("failed map reports a square");

    // no square means no corner, and the pad bit stays clear
    a_no_square_no_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[10:0] == 11'd0)) |-> (o_m_tdata[31:11] == 21'd0))
        else $error("corner given without a square");

    // a stalled result beat holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind largest_empty_square_finder_core lesf_checker u_lesf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
